[hdl/ows_pkg.sv]
// Shared types and constants for the 1-Wire ROM search engine.
// Used by ows_cfg_regs, ows_search_core and one_wire_rom_search.
package ows_pkg;

	localparam int ROM_BITS    = 64;
	localparam int KNOWN_IDS   = 4;
	localparam int ID_W        = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int SLOT_W      = 7;
	localparam int COUNT_W     = 4;
	localparam int POS_W       = $clog2(ROM_BITS + 1);
	localparam int ROM_IDX_W   = $clog2(ROM_BITS);
	localparam int S_DATA_W    = 8;
	localparam int M_DATA_W    = 24;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_SLOT  = 1'b1;

	typedef logic [KNOWN_IDS-1:0][ID_W-1:0] id_array_t;

	typedef struct packed {
		logic mode;
		logic id_bit;
		logic complement_bit;
	} ows_req_t;

	typedef struct packed {
		logic                 write_bit;
		logic [SLOT_W-1:0]    slot_index;
		logic                 pass_end;
		logic                 search_end;
		logic                 no_device;
		logic [COUNT_W-1:0]   device_count;
		logic [KNOWN_IDS-1:0] present_flags;
	} ows_result_t;

endpackage

[hdl/ows_cfg_regs.sv]
// Known ROM code registers, written through the configuration channel.
// Depends on ows_pkg.
module ows_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [ows_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ows_pkg::ID_W-1:0]        cfg_data,
	output ows_pkg::id_array_t              ids
);

	ows_pkg::id_array_t ids_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ids_q <= '0;
		end else if (cfg_valid) begin
			for (int k = 0; k < ows_pkg::KNOWN_IDS; k++) begin
				if (cfg_index == ows_pkg::CFG_INDEX_W'(k)) begin
					ids_q[k] <= cfg_data;
				end
			end
		end
	end

	assign ids = ids_q;

endmodule

[hdl/ows_search_core.sv]
// Search state and per-slot direction decision, pass end and ID match.
// Depends on ows_pkg.
module ows_search_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  ows_pkg::ows_req_t     req,
	input  ows_pkg::id_array_t    ids,
	output ows_pkg::ows_result_t  res
);

	logic [ows_pkg::ROM_BITS-1:0]  path_q, path_d;
	logic [ows_pkg::POS_W-1:0]     last_disc_q, last_disc_d;
	logic [ows_pkg::POS_W-1:0]     new_disc_q, new_disc_d;
	logic [ows_pkg::POS_W-1:0]     bit_pos_q, bit_pos_d;
	logic [ows_pkg::COUNT_W-1:0]   count_q, count_d;
	logic [ows_pkg::KNOWN_IDS-1:0] flags_q, flags_d;
	logic                          done_q, done_d;

	logic [ows_pkg::POS_W-1:0]     pos;
	logic [ows_pkg::ROM_IDX_W-1:0] idx;
	logic                          dir;
	logic [ows_pkg::ROM_BITS-1:0]  path_upd;

	always_comb begin
		pos = bit_pos_q;
		if (bit_pos_q == '0 || bit_pos_q > ows_pkg::POS_W'(ows_pkg::ROM_BITS)) begin
			pos = ows_pkg::POS_W'(1);
		end
		idx = ows_pkg::ROM_IDX_W'(pos - ows_pkg::POS_W'(1));
	end

	always_comb begin
		path_d      = path_q;
		last_disc_d = last_disc_q;
		new_disc_d  = new_disc_q;
		bit_pos_d   = bit_pos_q;
		count_d     = count_q;
		flags_d     = flags_q;
		done_d      = done_q;
		dir         = 1'b0;
		path_upd    = path_q;
		res         = '0;
		case (req.mode)
			ows_pkg::MODE_START: begin
				path_d      = '0;
				last_disc_d = '0;
				new_disc_d  = '0;
				bit_pos_d   = ows_pkg::POS_W'(1);
				count_d     = '0;
				flags_d     = '0;
				done_d      = 1'b0;
			end
			ows_pkg::MODE_SLOT: begin
				if (done_q) begin
					res.search_end    = 1'b1;
					res.device_count  = count_q;
					res.present_flags = flags_q;
				end else if (req.id_bit && req.complement_bit) begin
					bit_pos_d         = ows_pkg::POS_W'(1);
					done_d            = 1'b1;
					res.write_bit     = 1'b1;
					res.slot_index    = ows_pkg::SLOT_W'(pos);
					res.pass_end      = 1'b1;
					res.search_end    = 1'b1;
					res.no_device     = 1'b1;
					res.device_count  = count_q;
					res.present_flags = flags_q;
				end else begin
					if (req.id_bit != req.complement_bit) begin
						dir = req.id_bit;
					end else if (pos < last_disc_q) begin
						dir = path_q[idx];
						if (!dir) begin
							new_disc_d = pos;
						end
					end else if (pos == last_disc_q) begin
						dir = 1'b1;
					end else begin
						dir        = 1'b0;
						new_disc_d = pos;
					end
					path_upd[idx] = dir;
					path_d        = path_upd;
					if (pos >= ows_pkg::POS_W'(ows_pkg::ROM_BITS)) begin
						if (count_q != '1) begin
							count_d = count_q + ows_pkg::COUNT_W'(1);
						end
						for (int k = 0; k < ows_pkg::KNOWN_IDS; k++) begin
							if (ids[k][ows_pkg::ROM_BITS-1:0] == path_upd) begin
								flags_d[k] = 1'b1;
							end
						end
						last_disc_d = new_disc_d;
						new_disc_d  = '0;
						bit_pos_d   = ows_pkg::POS_W'(1);
						done_d      = (last_disc_d == '0);
						res.pass_end   = 1'b1;
						res.search_end = done_d;
					end else begin
						bit_pos_d = pos + ows_pkg::POS_W'(1);
					end
					res.write_bit     = dir;
					res.slot_index    = ows_pkg::SLOT_W'(pos);
					res.device_count  = count_d;
					res.present_flags = flags_d;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_q      <= '0;
			last_disc_q <= '0;
			new_disc_q  <= '0;
			bit_pos_q   <= ows_pkg::POS_W'(1);
			count_q     <= '0;
			flags_q     <= '0;
			done_q      <= 1'b0;
		end else if (fire) begin
			path_q      <= path_d;
			last_disc_q <= last_disc_d;
			new_disc_q  <= new_disc_d;
			bit_pos_q   <= bit_pos_d;
			count_q     <= count_d;
			flags_q     <= flags_d;
			done_q      <= done_d;
		end
	end

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req.mode == ows_pkg::MODE_START |=>
			count_q == '0 && flags_q == '0 && !done_q && bit_pos_q == ows_pkg::POS_W'(1))
		else $error("start did not clear search state");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_pos_q != '0 && bit_pos_q <= ows_pkg::POS_W'(ows_pkg::ROM_BITS))
		else $error("bit position out of range");

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !(fire && req.mode == ows_pkg::MODE_START) |=> done_q)
		else $error("search end dropped without a start");

	a_pass_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.pass_end |=> bit_pos_q == ows_pkg::POS_W'(1))
		else $error("pass end did not rewind bit position");

endmodule

[hdl/one_wire_rom_search.sv]
// 1-Wire ROM search engine, top level: input stage, result stage and handshakes.
// Depends on ows_pkg, ows_cfg_regs and ows_search_core.
//
// Usage: send a request with s_tuser = 0 to start a search, then one request
// per bit slot (s_tuser = 1) carrying the id bit and its complement read from
// the bus. Each request yields one result on the m_ side: the direction bit
// to send, the slot index, and pass/search status with the device count and
// presence flags. m_tlast marks the slot that closed a search pass.
// Known ROM codes are loaded through the cfg channel (index 0..3), which is
// always ready; write it only while no request is in flight.
// An accepted request passes through the input register and then the result
// register before its result is offered on m_.
// Throughput: one request per cycle while m_tready is high; the decision and
// the four 64-bit code compares sit between the input register and the result register.
// Reset clears the search state, the codes and the valid flags of both pipeline stages.
// When m_tready is low the result holds and the input stage fills; s_tready
// falls only once both stages hold a request.
module one_wire_rom_search (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ows_pkg::S_DATA_W-1:0]    s_tdata,  // id_bit, complement_bit, zero fill
	input  logic                            s_tuser,  // mode
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ows_pkg::M_DATA_W-1:0]    m_tdata,  // write_bit, slot_index[6:0], search_end,
	                                                  // no_device, device_count[3:0],
	                                                  // present_flags[3:0], zero fill
	output logic                            m_tlast,  // pass_end
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ows_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ows_pkg::ID_W-1:0]        cfg_data
);

	ows_pkg::id_array_t   ids;
	ows_pkg::ows_req_t    req_s1;
	logic                 valid_s1;
	ows_pkg::ows_result_t res;
	ows_pkg::ows_result_t res_s2;
	logic                 valid_s2;
	logic                 advance;
	logic                 accept;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign accept    = s_tvalid && s_tready;

	ows_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ids       (ids)
	);

	ows_search_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.ids    (ids),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.mode           <= s_tuser;
			req_s1.id_bit         <= s_tdata[0];
			req_s1.complement_bit <= s_tdata[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = res_s2.pass_end;
	assign m_tdata  = {
		(ows_pkg::M_DATA_W - 18)'(0),
		res_s2.present_flags,
		res_s2.device_count,
		res_s2.no_device,
		res_s2.search_end,
		res_s2.slot_index,
		res_s2.write_bit
	};

endmodule
